FILE: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg: sensor frame check and convert package
// Status codes, scaling modes, queue entry type, CRC-8 helper and the
// fixed-point scaling constants.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaled product: K * S + rounding term, S < 2^16, K < 2^18
  localparam int unsigned PROD_W = 34;
  localparam int unsigned QUOT_W = 18;

  localparam logic [17:0] K_CELSIUS    = 18'd17572;
  localparam logic [17:0] K_FAHRENHEIT = 18'd158148;
  localparam logic [17:0] K_HUMIDITY   = 18'd12500;

  localparam logic [PROD_W-1:0] RND_HALF  = 34'd32768;
  localparam logic [PROD_W-1:0] RND_FIFTH = 34'd163840;

  // floor(x / 5) = (x * ceil(2^21 / 5)) >> 21 for x < 2^18
  localparam logic [18:0] RECIP_5 = 19'd419431;
  localparam int unsigned RECIP_SHIFT = 21;

  localparam logic [15:0] OFS_CELSIUS    = 16'd4685;
  localparam logic [15:0] OFS_FAHRENHEIT = 16'd5233;
  localparam logic [15:0] OFS_HUMIDITY   = 16'd600;

  localparam logic [1:0] FULL_FRAME_BYTES = 2'd3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SHORT = 2'd1,
    STATUS_CRC   = 2'd2,
    STATUS_TYPE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SCALE_CELSIUS    = 3'b001,
    SCALE_FAHRENHEIT = 3'b010,
    SCALE_HUMIDITY   = 3'b100
  } scale_e;

  typedef struct packed {
    status_e     status;
    scale_e      scale;
    logic [13:0] mant;
  } frame_t;

  function automatic logic [7:0] crc8_byte(logic [7:0] crc, logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/sfc_front.sv
// ----------------------------------------------------------------------------
// sfc_front: frame classifier
// Holds the unit register, checks length, CRC-8 and type bit of an incoming
// frame and forms the queue entry with its status and scaling mode.
// ----------------------------------------------------------------------------
module sfc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic            kind_i,
  input  logic [1:0]      bytes_received_i,
  input  logic [15:0]     raw_word_i,
  input  logic [7:0]      crc_byte_i,
  input  logic            cfg_we_i,
  input  logic            cfg_data_i,
  output logic            push_o,
  output sfc_pkg::frame_t entry_o
);
  import sfc_pkg::*;

  logic       fahrenheit_q, fahrenheit_d;
  logic [7:0] crc_calc;

  always_comb begin
    fahrenheit_d = fahrenheit_q;
    if (cfg_we_i) begin
      fahrenheit_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fahrenheit_q <= 1'b0;
    end else begin
      fahrenheit_q <= fahrenheit_d;
    end
  end

  assign crc_calc = crc8_byte(crc8_byte(8'h00, raw_word_i[15:8]), raw_word_i[7:0]);

  always_comb begin
    if (bytes_received_i < FULL_FRAME_BYTES) begin
      entry_o.status = STATUS_SHORT;
    end else if (crc_calc != crc_byte_i) begin
      entry_o.status = STATUS_CRC;
    end else if (raw_word_i[1] != kind_i) begin
      entry_o.status = STATUS_TYPE;
    end else begin
      entry_o.status = STATUS_OK;
    end
    if (kind_i) begin
      entry_o.scale = SCALE_HUMIDITY;
    end else if (fahrenheit_q) begin
      entry_o.scale = SCALE_FAHRENHEIT;
    end else begin
      entry_o.scale = SCALE_CELSIUS;
    end
    entry_o.mant = raw_word_i[15:2];
  end

  assign push_o = accept_i;

endmodule

FILE: rtl/sfc_queue.sv
// ----------------------------------------------------------------------------
// sfc_queue: classified frame queue
// Short FIFO between the classifier and the scaling pipeline.
// ----------------------------------------------------------------------------
module sfc_queue #(
  parameter int unsigned Depth = sfc_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfc_pkg::frame_t data_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output sfc_pkg::frame_t data_o
);
  import sfc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/sfc_back.sv
// ----------------------------------------------------------------------------
// sfc_back: scaling pipeline
// Two-stage fixed-point conversion: multiply by the unit constant, then
// divide by 2^16 (and by 5 for Fahrenheit) and apply the offset; error entries give zero.
// ----------------------------------------------------------------------------
module sfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sfc_pkg::frame_t entry_i,
  output logic            valid_o,
  output logic [1:0]      status_o,
  output logic [15:0]     value_o
);
  import sfc_pkg::*;

  logic              s1_valid_q, s2_valid_q;
  status_e           s1_status_q, s2_status_q;
  scale_e            s1_scale_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [15:0]       value_q, value_d;

  logic [17:0]       k_sel;
  logic [PROD_W-1:0] rnd_sel;
  logic [QUOT_W-1:0] quot;
  logic [36:0]       recip_prod;
  logic [15:0]       q_sel;
  logic [15:0]       ofs_sel;
  logic [16:0]       diff;

  always_comb begin
    case (entry_i.scale)
      SCALE_FAHRENHEIT: begin
        k_sel   = K_FAHRENHEIT;
        rnd_sel = RND_FIFTH;
      end
      SCALE_HUMIDITY: begin
        k_sel   = K_HUMIDITY;
        rnd_sel = RND_HALF;
      end
      default: begin
        k_sel   = K_CELSIUS;
        rnd_sel = RND_HALF;
      end
    endcase
    prod_d = ({16'b0, k_sel} * {18'b0, entry_i.mant, 2'b00}) + rnd_sel;
  end

  assign quot       = prod_q[PROD_W-1:16];
  assign recip_prod = {19'b0, quot} * {18'b0, RECIP_5};

  always_comb begin
    case (s1_scale_q)
      SCALE_FAHRENHEIT: begin
        q_sel   = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        ofs_sel = OFS_FAHRENHEIT;
      end
      SCALE_HUMIDITY: begin
        q_sel   = quot[15:0];
        ofs_sel = OFS_HUMIDITY;
      end
      default: begin
        q_sel   = quot[15:0];
        ofs_sel = OFS_CELSIUS;
      end
    endcase
    diff    = {1'b0, q_sel} - {1'b0, ofs_sel};
    value_d = (s1_status_q == STATUS_OK) ? diff[15:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= entry_i.status;
    s1_scale_q  <= entry_i.scale;
    prod_q      <= prod_d;
    s2_status_q <= s1_status_q;
    value_q     <= value_d;
  end

  assign valid_o  = s2_valid_q;
  assign status_o = s2_status_q;
  assign value_o  = value_q;

endmodule

FILE: rtl/sensor_frame_check_convert_top.sv
// ----------------------------------------------------------------------------
// sensor_frame_check_convert_top: sensor frame check and convert
// Path from start to valid_o: queue entry, product register, result register.
// Throughput: one frame per cycle; busy stays low since the scaling
// pipeline drains the queue every cycle and the receiver cannot stall.
// Reset clears the unit register to Celsius and empties queue and pipeline.
// ----------------------------------------------------------------------------
module sensor_frame_check_convert_top #(
  parameter int unsigned QueueDepth = sfc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [1:0]  bytes_received_i,
  input  logic [15:0] raw_word_i,
  input  logic [7:0]  crc_byte_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [15:0] value_o
);
  import sfc_pkg::*;

  logic   accept;
  logic   push;
  logic   q_full, q_empty;
  frame_t entry, head;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !q_full;
  assign busy        = q_full;

  sfc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .kind_i           (kind_i),
    .bytes_received_i (bytes_received_i),
    .raw_word_i       (raw_word_i),
    .crc_byte_i       (crc_byte_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .push_o           (push),
    .entry_o          (entry)
  );

  sfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .pop_i   (!q_empty),
    .full_o  (q_full),
    .empty_o (q_empty),
    .data_o  (head)
  );

  sfc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (!q_empty),
    .entry_i  (head),
    .valid_o  (valid_o),
    .status_o (status_o),
    .value_o  (value_o)
  );

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 valid_o)
    else $error("accepted frame did not produce a result after three cycles");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, 3))
    else $error("result without a matching accepted frame");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != STATUS_OK)) |-> (value_o == 16'd0))
    else $error("nonzero value on an error result");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o == STATUS_OK)) |->
      (($signed(value_o) >= -16'sd5233) && ($signed(value_o) <= 16'sd26395)))
    else $error("converted value out of range");
`endif

endmodule
